/* design/dtwsl_pkg.sv */
// Shared types, constants and the sequencer program of the DDS tuning word loader.
package dtwsl_pkg;

   // Field widths
   localparam int REF_W   = 28;
   localparam int CTRL_W  = 8;
   localparam int FREQ_W  = 27;
   localparam int WORD_W  = 32;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 6;
   localparam int IDX_W   = 1;
   localparam int DATA_W  = 28;

   // Serial frame: four tuning word bytes and the control byte
   localparam int FRAME_BITS = 40;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

   // Pulse kinds
   localparam logic [KIND_W-1:0] KIND_STROBE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LATCH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESET  = 2'd2;

   // Commands
   localparam logic CMD_SET_FREQ = 1'b0;
   localparam logic CMD_RESET    = 1'b1;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_REF_CLOCK = 1'd0;
   localparam logic [IDX_W-1:0] REG_CONTROL   = 1'd1;

   // Program steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] S_DIV   = 3'd1;
   localparam logic [STEP_W-1:0] S_LOAD  = 3'd2;
   localparam logic [STEP_W-1:0] S_BITS  = 3'd3;
   localparam logic [STEP_W-1:0] S_LATCH = 3'd4;
   localparam logic [STEP_W-1:0] S_RST0  = 3'd5;
   localparam logic [STEP_W-1:0] S_RST1  = 3'd6;
   localparam logic [STEP_W-1:0] S_RST2  = 3'd7;

   // Next-step operations
   localparam int NX_W = 3;
   localparam logic [NX_W-1:0] NX_NEXT     = 3'd0;
   localparam logic [NX_W-1:0] NX_GOTO     = 3'd1;
   localparam logic [NX_W-1:0] NX_DISPATCH = 3'd2;
   localparam logic [NX_W-1:0] NX_WAIT_DIV = 3'd3;
   localparam logic [NX_W-1:0] NX_LOOP     = 3'd4;

   // One control word
   typedef struct packed {
      logic              in_ready;   // take a transaction in this step
      logic              div_load;   // start the divider on acceptance of a set frequency command
      logic              frame_load; // load frame shifter, clear bit count
      logic              emit;       // present a result this step
      logic [KIND_W-1:0] kind;
      logic              level_bit;  // data level from frame bit, else held level
      logic              pos_en;     // bit position from counter, else zero
      logic              word_en;    // carry tuning word and saturation, else zero
      logic              last;
      logic              shift;      // advance frame, count bit, update level
      logic [NX_W-1:0]   next_op;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // Status fed back to the sequencer
   typedef struct packed {
      logic accept;
      logic command;
      logic div_busy;
      logic bits_done;
      logic stall;
   } status_type;

   // Control store
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type c;
      c = '0;
      case (step)
         S_IDLE: begin
            c.in_ready = 1'b1; c.div_load = 1'b1;
            c.next_op = NX_DISPATCH; c.target = S_RST0;
         end
         S_DIV: begin
            c.next_op = NX_WAIT_DIV;
         end
         S_LOAD: begin
            c.frame_load = 1'b1; c.next_op = NX_NEXT;
         end
         S_BITS: begin
            c.emit = 1'b1; c.kind = KIND_STROBE; c.level_bit = 1'b1;
            c.pos_en = 1'b1; c.word_en = 1'b1; c.shift = 1'b1;
            c.next_op = NX_LOOP;
         end
         S_LATCH: begin
            c.emit = 1'b1; c.kind = KIND_LATCH; c.word_en = 1'b1;
            c.last = 1'b1; c.next_op = NX_GOTO; c.target = S_IDLE;
         end
         S_RST0: begin
            c.emit = 1'b1; c.kind = KIND_RESET; c.next_op = NX_NEXT;
         end
         S_RST1: begin
            c.emit = 1'b1; c.kind = KIND_STROBE; c.next_op = NX_NEXT;
         end
         S_RST2: begin
            c.emit = 1'b1; c.kind = KIND_LATCH; c.last = 1'b1;
            c.next_op = NX_GOTO; c.target = S_IDLE;
         end
         default: begin
            c.next_op = NX_GOTO; c.target = S_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

/* design/dtwsl_channels.sv */
// Handshake channel interfaces for commands, results and register writes.
interface dtwsl_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [dtwsl_pkg::FREQ_W-1:0]  frequency_hz;
   modport source (output valid, command, frequency_hz, input ready);
   modport sink   (input valid, command, frequency_hz, output ready);
endinterface

interface dtwsl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dtwsl_pkg::KIND_W-1:0]  pulse_kind;
   logic                          data_level;
   logic [dtwsl_pkg::POS_W-1:0]   bit_position;
   logic [dtwsl_pkg::WORD_W-1:0]  freq_word;
   logic                          saturated;
   logic                          last;
   modport source (output valid, pulse_kind, data_level, bit_position, freq_word,
                   saturated, last, input ready);
   modport sink   (input valid, pulse_kind, data_level, bit_position, freq_word,
                   saturated, last, output ready);
endinterface

interface dtwsl_csr_if;
   logic                          valid;
   logic                          ready;
   logic [dtwsl_pkg::IDX_W-1:0]   index;
   logic [dtwsl_pkg::DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/dtwsl_divider.sv */
// Restoring divider, one quotient bit per cycle, for the rounded tuning word.
module dtwsl_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [dtwsl_pkg::FREQ_W-1:0]  freq,
   input  logic [dtwsl_pkg::REF_W-1:0]   refclk,
   output logic                          busy,
   output logic [dtwsl_pkg::WORD_W-1:0]  word,
   output logic                          saturated
);
   import dtwsl_pkg::*;

   // Divisor is 2*ref; dividend is f*2^33 + ref, whose upper part is 2f
   localparam int DEN_W = REF_W + 1;
   localparam int CNT_W = $clog2(WORD_W);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [WORD_W-1:0]   low_ff, low_in;
   logic                sat_ff, sat_in;
   logic [DEN_W:0]      trial;
   logic                qbit;

   assign trial = {rem_ff, low_ff[WORD_W-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   // Load operands or take one quotient bit
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      sat_in  = sat_ff;
      if (load) begin
         // Quotient overflows 32 bits exactly when f >= ref (also covers ref of zero)
         sat_in  = ({1'b0, freq} >= refclk);
         busy_in = ({1'b0, freq} < refclk);
         cnt_in  = '0;
         rem_in  = {1'b0, freq, 1'b0};
         den_in  = {refclk, 1'b0};
         low_in  = WORD_W'(refclk);
      end else if (busy_ff) begin
         rem_in  = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         low_in  = {low_ff[WORD_W-2:0], qbit};
         cnt_in  = CNT_W'(cnt_ff + 1'b1);
         busy_in = (cnt_ff != {CNT_W{1'b1}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      sat_ff <= sat_in;
   end

   assign busy      = busy_ff;
   assign saturated = sat_ff;
   assign word      = sat_ff ? {WORD_W{1'b1}} : low_ff;
endmodule

/* design/dtwsl_sequencer.sv */
// Step counter with control store lookup and conditional jumps.
module dtwsl_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  dtwsl_pkg::status_type  status,
   output dtwsl_pkg::ctrl_type    ctrl
);
   import dtwsl_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] step_next;

   assign ctrl      = ucode(step_ff);
   assign step_next = STEP_W'(step_ff + 1'b1);

   // Pick the next step; hold while a result cannot be placed
   always_comb begin
      step_in = step_ff;
      if (!status.stall) begin
         case (ctrl.next_op)
            NX_NEXT:     step_in = step_next;
            NX_GOTO:     step_in = ctrl.target;
            NX_DISPATCH: begin
               if (status.accept) begin
                  step_in = (status.command == CMD_RESET) ? ctrl.target : step_next;
               end
            end
            NX_WAIT_DIV: step_in = status.div_busy ? step_ff : step_next;
            NX_LOOP:     step_in = status.bits_done ? step_next : step_ff;
            default:     step_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end
endmodule

/* design/dds_tuning_word_serial_loader.sv */
// DDS tuning word serial loader: top level with frame datapath and result register.
// Set frequency: an accept step, the divide step (passed straight through when
// saturated), a frame load, then 41 results one per cycle when results are taken
// at once. Reset command: 3 results, likewise one per cycle when taken at once.
// The radix-2 divider and the one-bit-per-cycle serial shift, which holds while a
// result cannot be placed, set the pace of a command.
// Synchronous reset returns the sequencer to idle, clears the data level and loads
// the register defaults; no pending result survives it.
module dds_tuning_word_serial_loader #(
   parameter logic [27:0] REF_CLOCK_RESET = 28'd180000000,
   parameter logic [7:0]  CONTROL_RESET   = 8'd1
) (
   input  logic        clock,
   input  logic        reset,
   dtwsl_req_if.sink   req_bus,
   dtwsl_rsp_if.source rsp_bus,
   dtwsl_csr_if.sink   csr_bus
);
   import dtwsl_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   logic [REF_W-1:0]      ref_ff, ref_in;
   logic [CTRL_W-1:0]     cbyte_ff, cbyte_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  level_ff, level_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic                  dlev_ff, dlev_in;
   logic [POS_W-1:0]      bpos_ff, bpos_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic                  sat_ff, sat_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic                  out_free;
   logic                  fire;
   logic                  div_busy;
   logic [WORD_W-1:0]     div_word;
   logic                  div_sat;

   assign req_bus.ready = ctrl.in_ready & !reset;
   assign accept        = req_bus.valid & req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = ctrl.emit & out_free;

   assign status.accept    = accept;
   assign status.command   = req_bus.command;
   assign status.div_busy  = div_busy;
   assign status.bits_done = (pos_ff == LAST_POS);
   assign status.stall     = ctrl.emit & !out_free;

   dtwsl_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   dtwsl_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .load      (accept & ctrl.div_load & (req_bus.command == CMD_SET_FREQ)),
      .freq      (req_bus.frequency_hz),
      .refclk    (ref_ff),
      .busy      (div_busy),
      .word      (div_word),
      .saturated (div_sat)
   );

   // Register writes
   assign csr_bus.ready = !reset;
   always_comb begin
      ref_in   = ref_ff;
      cbyte_in = cbyte_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_REF_CLOCK: ref_in   = csr_bus.data[REF_W-1:0];
            REG_CONTROL:   cbyte_in = csr_bus.data[CTRL_W-1:0];
            default:       ref_in   = ref_ff;
         endcase
      end
   end

   // Frame shifter, bit counter and held data level
   always_comb begin
      frame_in = frame_ff;
      pos_in   = pos_ff;
      level_in = level_ff;
      if (ctrl.frame_load) begin
         frame_in = {cbyte_ff, div_word};
         pos_in   = '0;
      end else if (fire && ctrl.shift) begin
         frame_in = {1'b0, frame_ff[FRAME_BITS-1:1]};
         pos_in   = POS_W'(pos_ff + 1'b1);
         level_in = frame_ff[0];
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & !rsp_bus.ready;
      kind_in      = kind_ff;
      dlev_in      = dlev_ff;
      bpos_in      = bpos_ff;
      word_in      = word_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         kind_in      = ctrl.kind;
         dlev_in      = ctrl.level_bit ? frame_ff[0] : level_ff;
         bpos_in      = ctrl.pos_en ? pos_ff : '0;
         word_in      = ctrl.word_en ? div_word : '0;
         sat_in       = ctrl.word_en & div_sat;
         last_in      = ctrl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff       <= REF_CLOCK_RESET;
         cbyte_ff     <= CONTROL_RESET;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_ff       <= ref_in;
         cbyte_ff     <= cbyte_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      pos_ff   <= pos_in;
      kind_ff  <= kind_in;
      dlev_ff  <= dlev_in;
      bpos_ff  <= bpos_in;
      word_ff  <= word_in;
      sat_ff   <= sat_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pulse_kind   = kind_ff;
   assign rsp_bus.data_level   = dlev_ff;
   assign rsp_bus.bit_position = bpos_ff;
   assign rsp_bus.freq_word    = word_ff;
   assign rsp_bus.saturated    = sat_ff;
   assign rsp_bus.last         = last_ff;
endmodule
